### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/irqnmi_pkg.sv
// types and constants of the irq/nmi latch and mask controller
`timescale 1ns / 1ps
package irqnmi_pkg;

    typedef enum logic [2:0] {
        REQ_LINE_CHANGE = 3'd0,
        REQ_IRQ_READ    = 3'd1,
        REQ_IRQ_MASK_WR = 3'd2,
        REQ_NMI_READ    = 3'd3,
        REQ_NMI_MASK_WR = 3'd4,
        REQ_LATCH_CLEAR = 3'd5,
        REQ_CASS_CLEAR  = 3'd6,
        REQ_NOP         = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        SRC_TIMER     = 3'd0,
        SRC_DISK      = 3'd1,
        SRC_MOTOR_OFF = 3'd2,
        SRC_UART_RCV  = 3'd3,
        SRC_UART_SND  = 3'd4,
        SRC_RESET     = 3'd5,
        SRC_CASS_RISE = 3'd6,
        SRC_CASS_FALL = 3'd7
    } t_src;

    // configuration register indexes
    localparam logic CFG_MODE_ONE   = 1'b0;
    localparam logic CFG_READ_CLR_T = 1'b1;

    // first-model irq latch bits
    localparam logic [7:0] FIRST_TIMER_BIT = 8'h80;
    localparam logic [7:0] FIRST_DISK_BIT  = 8'h40;
    // later-model irq latch bits
    localparam logic [7:0] UART_RCV_BIT  = 8'h20;
    localparam logic [7:0] UART_SND_BIT  = 8'h10;
    localparam logic [7:0] TIMER_BIT     = 8'h04;
    localparam logic [7:0] CASS_FALL_BIT = 8'h02;
    localparam logic [7:0] CASS_RISE_BIT = 8'h01;
    // nmi latch bits
    localparam logic [7:0] NMI_DISK_BIT   = 8'h80;
    localparam logic [7:0] NMI_MOTOR_BIT  = 8'h40;
    localparam logic [7:0] NMI_RESET_BIT  = 8'h20;

    localparam logic [7:0] NMI_LATCH_RST = 8'h01;
    localparam logic [7:0] NMI_MASK_RST  = NMI_RESET_BIT;

    typedef struct packed {
        logic [7:0] irq_latch;
        logic [7:0] irq_mask;
        logic [7:0] nmi_pend;
        logic [7:0] nmi_en;
        logic       irq_line;
        logic       nmi_line;
    } t_state;

    typedef struct packed {
        logic mode_one;
        logic read_clears_timer;
    } t_cfg;

    typedef struct packed {
        t_req       req_type;
        t_src       source;
        logic       level;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic       nmi_out;
        logic       nmi_seen_clear;
    } t_result;

    function automatic logic [7:0] set_bit(input logic [7:0] v, input logic [7:0] b,
                                           input logic on);
        return on ? (v | b) : (v & ~b);
    endfunction

endpackage

### rtl/irqnmi_update.sv
// next-state and result logic for one transaction
`timescale 1ns / 1ps
module irqnmi_update (
    input  irqnmi_pkg::t_state  i_state,
    input  irqnmi_pkg::t_cfg    i_cfg,
    input  irqnmi_pkg::t_item   i_item,
    output irqnmi_pkg::t_state  o_state,
    output irqnmi_pkg::t_result o_result
);
    import irqnmi_pkg::*;

    t_state     n_st;
    logic [7:0] rdata;
    logic       seen_clr;
    logic       nmi_eval;

    always_comb begin
        n_st     = i_state;
        rdata    = 8'h00;
        seen_clr = 1'b0;
        nmi_eval = 1'b0;
        case (i_item.req_type)
            REQ_LINE_CHANGE: begin
                case (i_item.source)
                    SRC_TIMER: begin
                        if (i_cfg.mode_one) begin
                            n_st.irq_latch = set_bit(n_st.irq_latch, FIRST_TIMER_BIT,
                                                     i_item.level);
                            if (i_item.level) n_st.irq_line = 1'b1;
                        end else begin
                            n_st.irq_latch = set_bit(n_st.irq_latch, TIMER_BIT, i_item.level);
                            n_st.irq_line  = |(n_st.irq_latch & n_st.irq_mask);
                        end
                    end
                    SRC_DISK: begin
                        if (i_cfg.mode_one) begin
                            n_st.irq_latch = set_bit(n_st.irq_latch, FIRST_DISK_BIT,
                                                     i_item.level);
                            if (i_item.level) n_st.irq_line = 1'b1;
                        end else begin
                            n_st.nmi_pend = set_bit(n_st.nmi_pend, NMI_DISK_BIT,
                                                    i_item.level);
                            nmi_eval = 1'b1;
                        end
                    end
                    SRC_MOTOR_OFF: begin
                        if (!i_cfg.mode_one) begin
                            n_st.nmi_pend = set_bit(n_st.nmi_pend, NMI_MOTOR_BIT,
                                                    i_item.level);
                            nmi_eval = 1'b1;
                        end
                    end
                    SRC_UART_RCV: begin
                        if (!i_cfg.mode_one) begin
                            n_st.irq_latch = set_bit(n_st.irq_latch, UART_RCV_BIT,
                                                     i_item.level);
                            n_st.irq_line  = |(n_st.irq_latch & n_st.irq_mask);
                        end
                    end
                    SRC_UART_SND: begin
                        if (!i_cfg.mode_one) begin
                            n_st.irq_latch = set_bit(n_st.irq_latch, UART_SND_BIT,
                                                     i_item.level);
                            n_st.irq_line  = |(n_st.irq_latch & n_st.irq_mask);
                        end
                    end
                    SRC_RESET: begin
                        if (i_cfg.mode_one) begin
                            // nmi line follows the button directly
                            n_st.nmi_line = i_item.level;
                            seen_clr      = !i_item.level;
                        end else begin
                            n_st.nmi_pend = set_bit(n_st.nmi_pend, NMI_RESET_BIT,
                                                    i_item.level);
                            nmi_eval = 1'b1;
                        end
                    end
                    SRC_CASS_RISE: begin
                        n_st.irq_latch = (n_st.irq_latch & ~CASS_RISE_BIT)
                                       | (n_st.irq_mask & CASS_RISE_BIT);
                        n_st.irq_line  = |(n_st.irq_latch & n_st.irq_mask);
                    end
                    default: begin
                        n_st.irq_latch = (n_st.irq_latch & ~CASS_FALL_BIT)
                                       | (n_st.irq_mask & CASS_FALL_BIT);
                        n_st.irq_line  = |(n_st.irq_latch & n_st.irq_mask);
                    end
                endcase
            end
            REQ_IRQ_READ: begin
                if (i_cfg.mode_one) begin
                    rdata          = i_state.irq_latch;
                    n_st.irq_latch = n_st.irq_latch & ~FIRST_TIMER_BIT;
                    n_st.irq_line  = |n_st.irq_latch;
                end else begin
                    rdata = ~i_state.irq_latch;
                    if (i_cfg.read_clears_timer) begin
                        n_st.irq_latch = n_st.irq_latch & ~TIMER_BIT;
                        n_st.irq_line  = |(n_st.irq_latch & n_st.irq_mask);
                    end
                end
            end
            REQ_IRQ_MASK_WR: begin
                n_st.irq_mask = i_item.write_data;
                n_st.irq_line = |(n_st.irq_latch & n_st.irq_mask);
            end
            REQ_NMI_READ: begin
                rdata = ~i_state.nmi_pend;
            end
            REQ_NMI_MASK_WR: begin
                n_st.nmi_en = i_item.write_data | NMI_RESET_BIT;
                nmi_eval    = 1'b1;
            end
            REQ_LATCH_CLEAR: begin
                n_st.irq_latch = 8'h00;
            end
            REQ_CASS_CLEAR: begin
                n_st.irq_latch = n_st.irq_latch & ~(CASS_FALL_BIT | CASS_RISE_BIT);
                n_st.irq_line  = |(n_st.irq_latch & n_st.irq_mask);
            end
            default: begin
            end
        endcase
        if (nmi_eval) begin
            n_st.nmi_line = |(n_st.nmi_pend & n_st.nmi_en);
            seen_clr      = !n_st.nmi_line;
        end
    end

    assign o_state                 = n_st;
    assign o_result.read_data      = rdata;
    assign o_result.irq_out        = n_st.irq_line;
    assign o_result.nmi_out        = n_st.nmi_line;
    assign o_result.nmi_seen_clear = seen_clr;

endmodule

### rtl/irq_nmi_latch_mask_controller.sv
// top level of the irq/nmi latch and mask controller
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Interrupt latch and mask controller for an 8-bit machine. Each input
// transaction is either a source line change (timer, disk, motor-off, uart,
// reset button, cassette edges) or a bus access (irq latch read, mask writes,
// nmi latch read, latch clear, cassette clear) or a no-op, and each gives
// exactly one result transaction carrying the read data, the irq and nmi
// lines after the update and the nmi seen-clear strobe. The controller takes
// one transaction per clock while the result side does not stall: the latch
// and mask registers are updated at the accepting edge by a single level of
// bit logic, and the result lands in one output register that is valid the
// cycle after acceptance. A new transaction is taken while that register is
// empty or being drained in the same cycle. Configuration (model-one rules,
// read-clears-timer clone option) is written through a simple write port
// and should only change while no transaction is in flight.
module irq_nmi_latch_mask_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_wdata,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [2:0] i_source,
    input  logic       i_level,
    input  logic [7:0] i_write_data,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_irq_out,
    output logic       o_nmi_out,
    output logic       o_nmi_seen_clear
);
    import irqnmi_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_cfg    r_cfg;
    t_item   item;
    t_result n_res;
    t_result r_res;
    logic    r_out_valid;
    logic    accept;

    // accept while the result register is empty or draining this cycle
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign item.req_type   = t_req'(i_req_type);
    assign item.source     = t_src'(i_source);
    assign item.level      = i_level;
    assign item.write_data = i_write_data;

    irqnmi_update u_update (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // latch, mask and line state advances on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.irq_latch <= 8'h00;
            r_state.irq_mask  <= 8'h00;
            r_state.nmi_pend  <= NMI_LATCH_RST;
            r_state.nmi_en    <= NMI_MASK_RST;
            r_state.irq_line  <= 1'b0;
            r_state.nmi_line  <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_one          <= 1'b0;
            r_cfg.read_clears_timer <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE_ONE:   r_cfg.mode_one          <= i_cfg_wdata;
                CFG_READ_CLR_T: r_cfg.read_clears_timer <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_data      = r_res.read_data;
    assign o_irq_out        = r_res.irq_out;
    assign o_nmi_out        = r_res.nmi_out;
    assign o_nmi_seen_clear = r_res.nmi_seen_clear;

    // the reset-button enable bit of the nmi mask can never be dropped
    `ASSERT_ALWAYS(a_nmi_mask_keeps_reset, i_clk, i_rst_n, r_state.nmi_en[5])
    // seen-clear is only reported together with a low nmi line
    `ASSERT_IMPL(a_seen_clear_low, i_clk, i_rst_n, o_valid && o_nmi_seen_clear, !o_nmi_out)
    // a latch clear empties the irq latch
    `ASSERT_NEXT(a_latch_clear, i_clk, i_rst_n,
                 accept && (i_req_type == REQ_LATCH_CLEAR), r_state.irq_latch == 8'h00)
    // reported lines match the held state once the result is presented
    `ASSERT_NEXT(a_lines_match, i_clk, i_rst_n, accept,
                 o_irq_out == r_state.irq_line && o_nmi_out == r_state.nmi_line)

endmodule

### bench/tb_irq_nmi_latch_mask_controller.sv
// self-checking testbench of the irq/nmi latch and mask controller
`timescale 1ns / 1ps
module tb_irq_nmi_latch_mask_controller;
    import irqnmi_pkg::*;

    localparam int unsigned RESET_CYCLES    = 7;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned PHASE_ITEMS     = 125;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned DRAIN_LIMIT     = 2000;
    localparam int unsigned TAIL_CYCLES     = 4;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    // keeps its own copy of latches, masks, lines and configuration and
    // queues the result each accepted transaction must produce
    class irq_nmi_scoreboard;
        t_cfg        cfg;
        t_state      st;
        t_result     expected_lines_q[$];
        int unsigned error_count;

        function new();
            cfg          = '0;
            st.irq_latch = '0;
            st.irq_mask  = '0;
            st.nmi_pend  = NMI_LATCH_RST;
            st.nmi_en    = NMI_MASK_RST;
            st.irq_line  = 1'b0;
            st.nmi_line  = 1'b0;
            error_count  = 0;
        endfunction

        function void set_cfg(logic idx, logic val);
            if (idx == CFG_MODE_ONE) begin
                cfg.mode_one = val;
            end else begin
                cfg.read_clears_timer = val;
            end
        endfunction

        function int pending();
            return expected_lines_q.size();
        endfunction

        function logic [7:0] with_bit(logic [7:0] v, logic [7:0] b, logic on);
            return on ? (v | b) : (v & ~b);
        endfunction

        function void refresh_irq();
            st.irq_line = |(st.irq_latch & st.irq_mask);
        endfunction

        // returns the seen-clear strobe: high when nmi ends up low
        function logic refresh_nmi();
            st.nmi_line = |(st.nmi_pend & st.nmi_en);
            return !st.nmi_line;
        endfunction

        function t_result predict_lines(t_item it);
            t_result r;
            logic    m1;
            r  = '0;
            m1 = cfg.mode_one;
            case (it.req_type)
                REQ_LINE_CHANGE: begin
                    case (it.source)
                        SRC_TIMER: begin
                            if (m1) begin
                                st.irq_latch = with_bit(st.irq_latch, FIRST_TIMER_BIT,
                                                        it.level);
                                if (it.level) st.irq_line = 1'b1;
                            end else begin
                                st.irq_latch = with_bit(st.irq_latch, TIMER_BIT, it.level);
                                refresh_irq();
                            end
                        end
                        SRC_DISK: begin
                            if (m1) begin
                                st.irq_latch = with_bit(st.irq_latch, FIRST_DISK_BIT,
                                                        it.level);
                                if (it.level) st.irq_line = 1'b1;
                            end else begin
                                st.nmi_pend = with_bit(st.nmi_pend, NMI_DISK_BIT, it.level);
                                r.nmi_seen_clear = refresh_nmi();
                            end
                        end
                        SRC_MOTOR_OFF: begin
                            if (!m1) begin
                                st.nmi_pend = with_bit(st.nmi_pend, NMI_MOTOR_BIT, it.level);
                                r.nmi_seen_clear = refresh_nmi();
                            end
                        end
                        SRC_UART_RCV: begin
                            if (!m1) begin
                                st.irq_latch = with_bit(st.irq_latch, UART_RCV_BIT, it.level);
                                refresh_irq();
                            end
                        end
                        SRC_UART_SND: begin
                            if (!m1) begin
                                st.irq_latch = with_bit(st.irq_latch, UART_SND_BIT, it.level);
                                refresh_irq();
                            end
                        end
                        SRC_RESET: begin
                            if (m1) begin
                                st.nmi_line      = it.level;
                                r.nmi_seen_clear = !it.level;
                            end else begin
                                st.nmi_pend = with_bit(st.nmi_pend, NMI_RESET_BIT, it.level);
                                r.nmi_seen_clear = refresh_nmi();
                            end
                        end
                        SRC_CASS_RISE: begin
                            st.irq_latch = (st.irq_latch & ~CASS_RISE_BIT)
                                         | (st.irq_mask & CASS_RISE_BIT);
                            refresh_irq();
                        end
                        default: begin
                            st.irq_latch = (st.irq_latch & ~CASS_FALL_BIT)
                                         | (st.irq_mask & CASS_FALL_BIT);
                            refresh_irq();
                        end
                    endcase
                end
                REQ_IRQ_READ: begin
                    if (m1) begin
                        r.read_data  = st.irq_latch;
                        st.irq_latch = st.irq_latch & ~FIRST_TIMER_BIT;
                        st.irq_line  = |st.irq_latch;
                    end else begin
                        r.read_data = ~st.irq_latch;
                        if (cfg.read_clears_timer) begin
                            st.irq_latch = st.irq_latch & ~TIMER_BIT;
                            refresh_irq();
                        end
                    end
                end
                REQ_IRQ_MASK_WR: begin
                    st.irq_mask = it.write_data;
                    refresh_irq();
                end
                REQ_NMI_READ: begin
                    r.read_data = ~st.nmi_pend;
                end
                REQ_NMI_MASK_WR: begin
                    st.nmi_en        = it.write_data | NMI_RESET_BIT;
                    r.nmi_seen_clear = refresh_nmi();
                end
                REQ_LATCH_CLEAR: begin
                    st.irq_latch = '0;
                end
                REQ_CASS_CLEAR: begin
                    st.irq_latch = st.irq_latch & ~(CASS_FALL_BIT | CASS_RISE_BIT);
                    refresh_irq();
                end
                default: begin
                end
            endcase
            r.irq_out = st.irq_line;
            r.nmi_out = st.nmi_line;
            return r;
        endfunction

        function void note_transaction(t_item it);
            expected_lines_q.push_back(predict_lines(it));
        endfunction

        function void check_transaction(t_result got);
            t_result want;
            if (expected_lines_q.size() == 0) begin
                $error("result transaction with no expectation waiting");
                error_count++;
                return;
            end
            want = expected_lines_q.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %02h, actual %02h", want.read_data, got.read_data);
                error_count++;
            end
            if (got.irq_out !== want.irq_out) begin
                $error("irq_out: expected %0b, actual %0b", want.irq_out, got.irq_out);
                error_count++;
            end
            if (got.nmi_out !== want.nmi_out) begin
                $error("nmi_out: expected %0b, actual %0b", want.nmi_out, got.nmi_out);
                error_count++;
            end
            if (got.nmi_seen_clear !== want.nmi_seen_clear) begin
                $error("nmi_seen_clear: expected %0b, actual %0b",
                       want.nmi_seen_clear, got.nmi_seen_clear);
                error_count++;
            end
        endfunction
    endclass

    // every input starts at a known value
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic       i_cfg_idx    = 1'b0;
    logic       i_cfg_wdata  = 1'b0;
    logic       i_valid      = 1'b0;
    logic [2:0] i_req_type   = '0;
    logic [2:0] i_source     = '0;
    logic       i_level      = 1'b0;
    logic [7:0] i_write_data = '0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_read_data;
    logic       o_irq_out;
    logic       o_nmi_out;
    logic       o_nmi_seen_clear;

    // request from the stimulus to the result side for one long hold-off
    logic        hold_off_req = 1'b0;
    int unsigned cycle_count  = 0;

    irq_nmi_scoreboard sb = new();

    irq_nmi_latch_mask_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_source         (i_source),
        .i_level          (i_level),
        .i_write_data     (i_write_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_read_data      (o_read_data),
        .o_irq_out        (o_irq_out),
        .o_nmi_out        (o_nmi_out),
        .o_nmi_seen_clear (o_nmi_seen_clear)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // monitor: values seen at the edge are the pre-edge ones, since both the
    // block and the drivers update through nonblocking assignments
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_transaction(t_item'{t_req'(i_req_type), t_src'(i_source),
                                        i_level, i_write_data});
        end
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_transaction(t_result'{o_read_data, o_irq_out, o_nmi_out,
                                           o_nmi_seen_clear});
        end
    end

    // offer one input transaction and return at the edge that accepts it;
    // valid stays high so the next offer can follow back to back
    task automatic offer(t_req req, t_src src, logic lvl, logic [7:0] wd);
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_source     <= src;
        i_level      <= lvl;
        i_write_data <= wd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // stop offering and wait for every queued result; the first edge makes
    // sure the monitor has noted the last accepted transaction
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // one register write; the trailing edge keeps back-to-back writes from
    // putting two assignments on the enable in one step
    task automatic write_cfg(logic idx, logic val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_cfg(idx, val);
        @(posedge i_clk);
    endtask

    // result side: stretches of always-ready, coin-flip and mostly-stalled,
    // plus one long hold-off on request so the block backs up into its input
    initial begin : result_sink
        int unsigned style;
        int unsigned stretch;
        forever begin
            if (hold_off_req) begin
                repeat (HOLD_OFF_CYCLES) begin
                    @(posedge i_clk);
                    i_ready <= 1'b0;
                end
                hold_off_req = 1'b0;
            end else begin
                style   = $urandom_range(0, 2);
                stretch = $urandom_range(4, 40);
                repeat (stretch) begin
                    @(posedge i_clk);
                    case (style)
                        0:       i_ready <= 1'b1;
                        1:       i_ready <= 1'($urandom_range(0, 1));
                        default: i_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned pick;
        int unsigned drain_wait;
        t_req        req;
        logic [7:0]  wd;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: later-model rules, clone option off (reset settings)
        offer(REQ_NMI_READ,    SRC_TIMER,     1'b0, 8'h00);  // inverted reset latch
        offer(REQ_IRQ_MASK_WR, SRC_TIMER,     1'b0, 8'hFF);
        offer(REQ_LINE_CHANGE, SRC_TIMER,     1'b1, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_UART_RCV,  1'b1, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_UART_SND,  1'b1, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_CASS_RISE, 1'b0, 8'h00);  // mask bit copied, level ignored
        offer(REQ_LINE_CHANGE, SRC_CASS_FALL, 1'b1, 8'h00);
        offer(REQ_IRQ_READ,    SRC_TIMER,     1'b0, 8'h00);
        offer(REQ_CASS_CLEAR,  SRC_TIMER,     1'b0, 8'h00);
        offer(REQ_NMI_MASK_WR, SRC_TIMER,     1'b0, 8'hFF);
        offer(REQ_LINE_CHANGE, SRC_DISK,      1'b1, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_MOTOR_OFF, 1'b1, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_RESET,     1'b1, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_DISK,      1'b0, 8'h00);
        offer(REQ_NMI_MASK_WR, SRC_TIMER,     1'b0, 8'h00);  // reset bit stays masked in
        offer(REQ_LINE_CHANGE, SRC_RESET,     1'b0, 8'h00);  // nmi drops, seen-clear
        offer(REQ_LATCH_CLEAR, SRC_TIMER,     1'b0, 8'h00);  // irq line keeps its value
        offer(REQ_IRQ_MASK_WR, SRC_TIMER,     1'b0, 8'h00);
        offer(REQ_NOP,         SRC_CASS_FALL, 1'b1, 8'hFF);

        // directed: first-model rules
        wait_drained();
        write_cfg(CFG_MODE_ONE, 1'b1);
        offer(REQ_LINE_CHANGE, SRC_TIMER,     1'b1, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_DISK,      1'b1, 8'h00);
        offer(REQ_IRQ_READ,    SRC_TIMER,     1'b0, 8'h00);  // acknowledges timer bit
        offer(REQ_LINE_CHANGE, SRC_DISK,      1'b0, 8'h00);  // irq line held
        offer(REQ_LINE_CHANGE, SRC_RESET,     1'b1, 8'h00);  // nmi follows level
        offer(REQ_LINE_CHANGE, SRC_RESET,     1'b0, 8'h00);
        offer(REQ_LINE_CHANGE, SRC_MOTOR_OFF, 1'b1, 8'h00);  // ignored here
        offer(REQ_LINE_CHANGE, SRC_UART_RCV,  1'b1, 8'h00);  // ignored here

        // random phases: fixed corner settings first, then random ones
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            if (phase < 4) begin
                write_cfg(CFG_MODE_ONE,   (phase == 1) || (phase == 2));
                write_cfg(CFG_READ_CLR_T, (phase == 0) || (phase == 2));
            end else begin
                write_cfg(CFG_MODE_ONE,   1'($urandom_range(0, 1)));
                write_cfg(CFG_READ_CLR_T, 1'($urandom_range(0, 1)));
            end
            // back-pressure: result side holds off while offers keep coming
            if (phase == 1) hold_off_req = 1'b1;
            burst_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap != 0) begin
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 10);
                end
                // line changes dominate so the latches see real traffic
                pick = $urandom_range(0, 99);
                if (pick < 45)      req = REQ_LINE_CHANGE;
                else if (pick < 57) req = REQ_IRQ_READ;
                else if (pick < 66) req = REQ_IRQ_MASK_WR;
                else if (pick < 73) req = REQ_NMI_READ;
                else if (pick < 81) req = REQ_NMI_MASK_WR;
                else if (pick < 86) req = REQ_LATCH_CLEAR;
                else if (pick < 95) req = REQ_CASS_CLEAR;
                else                req = REQ_NOP;
                case ($urandom_range(0, 7))
                    0:       wd = 8'h00;
                    1:       wd = 8'hFF;
                    default: wd = 8'($urandom_range(0, 255));
                endcase
                offer(req, t_src'(3'($urandom_range(0, 7))), 1'($urandom_range(0, 1)), wd);
                burst_left--;
                // sender pause until the block has handed back everything
                if (phase == 3 && n == 60) wait_drained();
            end
        end

        // end of stimulus: drain with a bound, then watch a few more cycles
        i_valid <= 1'b0;
        @(posedge i_clk);
        drain_wait = 0;
        while (sb.pending() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result transactions never arrived", sb.pending());
            sb.error_count++;
        end
        if (sb.error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
